/* rtl/core/directory_entry_name_matcher_top_defines.svh */
// ----------------------------------------------------------------------------
// Directory entry name matcher assertion macros
// Shared assertion forms for the matcher checker.
// ----------------------------------------------------------------------------
`ifndef DIRECTORY_ENTRY_NAME_MATCHER_TOP_DEFINES_SVH
`define DIRECTORY_ENTRY_NAME_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DENM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("directory entry matcher check failed");

// next-cycle implication, disabled during reset
`define DENM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("directory entry matcher check failed");

`endif

/* rtl/core/denm_pkg.sv */
// ----------------------------------------------------------------------------
// Directory entry name matcher package
// Entry layout constants, entry kind codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package denm_pkg;

	localparam int unsigned POS_W       = 5;
	localparam int unsigned CFG_IDX_W   = 2;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned NAME_HI_W   = 24;
	localparam int unsigned OUT_DATA_W  = 40;

	localparam logic [POS_W-1:0] NAME_BYTES  = 5'd11;
	localparam logic [POS_W-1:0] ATTR_POS    = 5'd11;
	localparam logic [POS_W-1:0] CLUS_HI_POS = 5'd20;
	localparam logic [POS_W-1:0] CLUS_LO_POS = 5'd26;
	localparam logic [POS_W-1:0] LAST_POS    = 5'd31;

	localparam logic [7:0] END_MARK     = 8'h00;
	localparam logic [7:0] DELETED_MARK = 8'hE5;
	localparam logic [3:0] LFN_NIBBLE   = 4'hF;
	localparam int unsigned DIR_BIT_IDX = 4;

	localparam logic [CFG_IDX_W-1:0] REG_NAME_LOW   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NAME_HIGH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPORT_ALL = 2'd2;

	typedef enum logic [2:0] {
		KIND_END     = 3'd0,
		KIND_DELETED = 3'd1,
		KIND_LONG    = 3'd2,
		KIND_NOMATCH = 3'd3,
		KIND_MATCH   = 3'd4
	} kind_t;

endpackage

`default_nettype wire

/* rtl/core/directory_entry_name_matcher_top.sv */
// ----------------------------------------------------------------------------
// Directory entry name matcher
// Scans 32-byte FAT directory entries for a wanted 8.3 short name.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one directory byte per request in tdata; tuser set marks
//   the first byte of a new search and restarts at entry byte 0.
//   m_axis carries one result per entry that ends the search, or per
//   entry in listing mode; tuser holds the entry kind, tdata the first
//   cluster and directory bit, tlast a search end (match or end of dir).
//   cfg_we/cfg_index/cfg_data write the wanted name and the listing mode;
//   write only while the block is idle.
// Timing:
//   A byte is registered on acceptance and evaluated from the input
//   register; an entry's result is registered once byte 31 is evaluated.
//   One byte is accepted every cycle while no untaken result stalls it, set
//   by the single input register feeding the result register.
// Reset and stalls:
//   Reset clears position, match state and the finished flag, and sets the
//   wanted name to zero. While the result register holds an untaken result
//   the input register holds its byte and s_axis_tready drops once it is full.
//   After a search ends, bytes are dropped until a new start.
// ----------------------------------------------------------------------------
`default_nettype none

module directory_entry_name_matcher_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  wire logic [7:0]                         s_axis_tdata,  // dir_byte
	input  wire logic                               s_axis_tuser,  // start_search
	output logic                                    m_axis_tvalid,
	input  wire logic                               m_axis_tready,
	// start_cluster[31:0], dir_flag[32], zero fill[39:33]
	output logic [denm_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	output logic [2:0]                              m_axis_tuser,  // entry_kind
	output logic                                    m_axis_tlast,  // search_done
	input  wire logic                               cfg_we,
	input  wire logic [denm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [denm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                       valid_s1;
	logic [7:0]                 byte_s1;
	logic                       start_s1;

	logic [denm_pkg::POS_W-1:0] pos_q;
	logic                       eq_q;
	logic [7:0]                 first_q;
	logic [7:0]                 attr_q;
	logic [15:0]                clus_hi_q;
	logic [15:0]                clus_lo_q;
	logic                       fin_q;

	logic [63:0]                name_lo_q;
	logic [denm_pkg::NAME_HI_W-1:0] name_hi_q;
	logic                       report_all_q;

	logic                       out_valid_q;
	denm_pkg::kind_t            out_kind_q;
	logic [31:0]                out_clus_q;
	logic                       out_dir_q;
	logic                       out_done_q;

	logic [15:0][7:0]           wanted;
	logic [denm_pkg::POS_W-1:0] cur_pos;
	logic                       cur_fin;
	logic                       live;
	logic                       byte_eq;
	logic                       is_last;
	denm_pkg::kind_t            kind;
	logic                       done;
	logic                       emit;
	logic                       advance;

	assign wanted  = {40'd0, name_hi_q, name_lo_q};
	assign cur_pos = start_s1 ? '0 : pos_q;
	assign cur_fin = start_s1 ? 1'b0 : fin_q;
	assign live    = valid_s1 && !cur_fin;
	assign byte_eq = (byte_s1 == wanted[cur_pos[3:0]]);
	assign is_last = (cur_pos == denm_pkg::LAST_POS);

	always_comb begin
		priority if (first_q == denm_pkg::END_MARK) begin
			kind = denm_pkg::KIND_END;
		end else if (first_q == denm_pkg::DELETED_MARK) begin
			kind = denm_pkg::KIND_DELETED;
		end else if (attr_q[3:0] == denm_pkg::LFN_NIBBLE) begin
			kind = denm_pkg::KIND_LONG;
		end else if (eq_q) begin
			kind = denm_pkg::KIND_MATCH;
		end else begin
			kind = denm_pkg::KIND_NOMATCH;
		end
	end

	assign done          = (kind == denm_pkg::KIND_END) || (kind == denm_pkg::KIND_MATCH);
	assign emit          = live && is_last && (done || report_all_q);
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	// entry state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			eq_q      <= 1'b1;
			first_q   <= '0;
			attr_q    <= '0;
			clus_hi_q <= '0;
			clus_lo_q <= '0;
			fin_q     <= 1'b0;
		end else if (advance) begin
			if (live) begin
				if (cur_pos < denm_pkg::NAME_BYTES) begin
					eq_q <= (cur_pos == '0) ? byte_eq : (eq_q && byte_eq);
				end
				if (cur_pos == '0) begin
					first_q <= byte_s1;
				end
				if (cur_pos == denm_pkg::ATTR_POS) begin
					attr_q <= byte_s1;
				end
				if (cur_pos == denm_pkg::CLUS_HI_POS) begin
					clus_hi_q[7:0] <= byte_s1;
				end
				if (cur_pos == denm_pkg::CLUS_HI_POS + 5'd1) begin
					clus_hi_q[15:8] <= byte_s1;
				end
				if (cur_pos == denm_pkg::CLUS_LO_POS) begin
					clus_lo_q[7:0] <= byte_s1;
				end
				if (cur_pos == denm_pkg::CLUS_LO_POS + 5'd1) begin
					clus_lo_q[15:8] <= byte_s1;
				end
				pos_q <= cur_pos + 5'd1;
				fin_q <= is_last && done;
			end
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_lo_q    <= '0;
			name_hi_q    <= '0;
			report_all_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				denm_pkg::REG_NAME_LOW:   name_lo_q    <= cfg_data;
				denm_pkg::REG_NAME_HIGH:  name_hi_q    <= cfg_data[denm_pkg::NAME_HI_W-1:0];
				denm_pkg::REG_REPORT_ALL: report_all_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_kind_q <= kind;
			out_done_q <= done;
			if (kind == denm_pkg::KIND_END) begin
				out_clus_q <= '0;
				out_dir_q  <= 1'b0;
			end else begin
				out_clus_q <= {clus_hi_q, clus_lo_q};
				out_dir_q  <= attr_q[denm_pkg::DIR_BIT_IDX];
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_dir_q, out_clus_q};
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_done_q;

endmodule

`default_nettype wire

/* rtl/core/denm_checker.sv */
// ----------------------------------------------------------------------------
// Directory entry name matcher checker
// Port-level checks on result kinds, search end and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none
`include "directory_entry_name_matcher_top_defines.svh"

module denm_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            m_axis_tvalid,
	input wire logic                            m_axis_tready,
	input wire logic [denm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input wire logic [2:0]                      m_axis_tuser,
	input wire logic                            m_axis_tlast
);

	logic end_kind;
	logic closing_kind;
	logic open_kind;
	logic held;

	assign end_kind     = (m_axis_tuser == denm_pkg::KIND_END);
	assign closing_kind = end_kind || (m_axis_tuser == denm_pkg::KIND_MATCH);
	assign open_kind    = (m_axis_tuser == denm_pkg::KIND_DELETED) ||
	                      (m_axis_tuser == denm_pkg::KIND_LONG) ||
	                      (m_axis_tuser == denm_pkg::KIND_NOMATCH);
	assign held         = m_axis_tvalid && !m_axis_tready;

	`DENM_ASSERT_NOW(a_done_kind, m_axis_tvalid && m_axis_tlast, closing_kind)

	`DENM_ASSERT_NOW(a_open_kind, m_axis_tvalid && !m_axis_tlast, open_kind)

	`DENM_ASSERT_NOW(a_end_zero, m_axis_tvalid && end_kind, m_axis_tdata == '0)

	`DENM_ASSERT_NEXT(a_stall_hold, held, m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))

endmodule

bind directory_entry_name_matcher_top denm_checker u_denm_checker (.*);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Directory entry name matcher testbench
// Streams 32-byte directory entries through the matcher under several name
// and listing settings, predicts each classified entry in step with accepted
// bytes and checks every result against the prediction, in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	typedef struct {
		logic [7:0] dbyte;
		logic       st;
	} dir_req_t;

	typedef struct {
		denm_pkg::kind_t kind;
		logic [31:0]     clus;
		logic            is_dir;
		logic            done;
	} entry_result_t;

	typedef enum {
		GEN_END,
		GEN_DELETED,
		GEN_LONG,
		GEN_MATCH,
		GEN_NEAR,
		GEN_OTHER
	} entry_gen_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [7:0]                      s_tdata = 8'h00;
	logic                            s_tuser = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [denm_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [2:0]                      m_tuser;
	logic                            m_tlast;
	logic                            cfg_we = 1'b0;
	logic [denm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [denm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            hold_go = 1'b0;

	dir_req_t      dir_req_q[$];
	entry_result_t entry_results_q[$];
	int            items_queued = 0;
	int            fail_cnt = 0;

	// shadow of the configuration and of the entry scan
	logic [63:0] want_lo = '0;
	logic [23:0] want_hi = '0;
	logic        list_all = 1'b0;
	logic [4:0]  ent_pos = '0;
	logic        name_ok = 1'b1;
	logic [7:0]  lead_byte = '0;
	logic [7:0]  attr_byte = '0;
	logic [15:0] clus_hi = '0;
	logic [15:0] clus_lo = '0;
	logic        search_over = 1'b0;

	directory_entry_name_matcher_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata),
		.m_axis_tuser  (m_tuser),
		.m_axis_tlast  (m_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] wanted_at(int p);
		if (p < 8)
			return want_lo[p*8 +: 8];
		return want_hi[(p-8)*8 +: 8];
	endfunction

	task automatic track_dir_byte(logic [7:0] b, logic st);
		int              p;
		logic            eq;
		logic            done;
		denm_pkg::kind_t kind;
		entry_result_t   r;
		if (st) begin
			ent_pos     = '0;
			search_over = 1'b0;
		end
		if (search_over)
			return;
		p = ent_pos;
		if (p < denm_pkg::NAME_BYTES) begin
			eq      = (b == wanted_at(p));
			name_ok = (p == 0) ? eq : (name_ok & eq);
		end
		if (p == 0)
			lead_byte = b;
		if (p == denm_pkg::ATTR_POS)
			attr_byte = b;
		if (p == denm_pkg::CLUS_HI_POS)
			clus_hi[7:0] = b;
		if (p == denm_pkg::CLUS_HI_POS + 1)
			clus_hi[15:8] = b;
		if (p == denm_pkg::CLUS_LO_POS)
			clus_lo[7:0] = b;
		if (p == denm_pkg::CLUS_LO_POS + 1)
			clus_lo[15:8] = b;
		ent_pos = ent_pos + 5'd1;
		if (p != denm_pkg::LAST_POS)
			return;
		if (lead_byte == denm_pkg::END_MARK)
			kind = denm_pkg::KIND_END;
		else if (lead_byte == denm_pkg::DELETED_MARK)
			kind = denm_pkg::KIND_DELETED;
		else if (attr_byte[3:0] == denm_pkg::LFN_NIBBLE)
			kind = denm_pkg::KIND_LONG;
		else if (name_ok)
			kind = denm_pkg::KIND_MATCH;
		else
			kind = denm_pkg::KIND_NOMATCH;
		done = (kind == denm_pkg::KIND_END) || (kind == denm_pkg::KIND_MATCH);
		if (done)
			search_over = 1'b1;
		if (!done && !list_all)
			return;
		r.kind   = kind;
		r.done   = done;
		r.clus   = (kind == denm_pkg::KIND_END) ? 32'h0 : {clus_hi, clus_lo};
		r.is_dir = (kind == denm_pkg::KIND_END) ? 1'b0 : attr_byte[denm_pkg::DIR_BIT_IDX];
		entry_results_q.push_back(r);
	endtask

	task automatic push_req(logic [7:0] b, logic st);
		dir_req_t r;
		r.dbyte = b;
		r.st    = st;
		dir_req_q.push_back(r);
		items_queued++;
	endtask

	task automatic add_fill(logic [7:0] v, logic st);
		for (int k = 0; k < 32; k++)
			push_req(v, st && k == 0);
	endtask

	task automatic add_noise(int n, bit allow_start);
		for (int k = 0; k < n; k++)
			push_req(8'($urandom_range(0, 255)), allow_start && $urandom_range(0, 19) == 0);
	endtask

	task automatic add_entry(entry_gen_t g, logic st, int len);
		logic [7:0] e [32];
		int         k;
		for (k = 0; k < 32; k++)
			e[k] = 8'($urandom_range(0, 255));
		if (g == GEN_MATCH || g == GEN_NEAR)
			for (k = 0; k < 11; k++)
				e[k] = wanted_at(k);
		if (g == GEN_NEAR) begin
			k = $urandom_range(0, 10);
			e[k] = e[k] ^ 8'($urandom_range(1, 255));
		end
		if ((g == GEN_OTHER || g == GEN_LONG) &&
		    (e[0] == denm_pkg::END_MARK || e[0] == denm_pkg::DELETED_MARK))
			e[0] = 8'h41;
		if (g == GEN_END)
			e[0] = denm_pkg::END_MARK;
		if (g == GEN_DELETED)
			e[0] = denm_pkg::DELETED_MARK;
		if (g == GEN_LONG)
			e[11][3:0] = denm_pkg::LFN_NIBBLE;
		else if (e[11][3:0] == denm_pkg::LFN_NIBBLE)
			e[11][0] = 1'b0;
		if ($urandom_range(0, 5) == 0) begin
			e[20] = {8{e[20][0]}};
			e[21] = e[20];
			e[26] = e[20];
			e[27] = e[20];
		end
		for (k = 0; k < len; k++)
			push_req(e[k], st && k == 0);
	endtask

	task automatic add_search();
		int         n;
		int         r;
		entry_gen_t g;
		if ($urandom_range(0, 11) == 0)
			add_entry(GEN_OTHER, 1'b1, $urandom_range(1, 31));
		n = $urandom_range(1, 5);
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(0, 9);
			if (k == n - 1)
				g = (r < 5) ? GEN_MATCH : (r < 8) ? GEN_END : (r < 9) ? GEN_NEAR : GEN_OTHER;
			else
				g = (r < 2) ? GEN_DELETED : (r < 4) ? GEN_LONG : (r < 7) ? GEN_NEAR : GEN_OTHER;
			add_entry(g, k == 0, 32);
		end
		if ($urandom_range(0, 3) == 0)
			add_noise($urandom_range(1, 40), 1'b1);
	endtask

	task automatic cfg_write(logic [denm_pkg::CFG_IDX_W-1:0] idx,
	                         logic [denm_pkg::CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			denm_pkg::REG_NAME_LOW:   want_lo = val;
			denm_pkg::REG_NAME_HIGH:  want_hi = val[denm_pkg::NAME_HI_W-1:0];
			denm_pkg::REG_REPORT_ALL: list_all = val[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [63:0] lo, logic [23:0] hi, logic all);
		cfg_write(denm_pkg::REG_NAME_LOW, lo);
		cfg_write(denm_pkg::REG_NAME_HIGH, 64'(hi));
		cfg_write(denm_pkg::REG_REPORT_ALL, 64'(all));
	endtask

	task automatic wait_idle();
		while (dir_req_q.size() != 0 || s_tvalid || entry_results_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// sender: bursts of requests with random gaps
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		dir_req_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				track_dir_byte(s_tdata, s_tuser);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (dir_req_q.size() != 0) begin
					nxt = dir_req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.dbyte;
					s_tuser  <= nxt.st;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: stall rate redrawn at regular intervals, one long hold-off on request
	int rx_cyc = 0;
	int stall_pct = 0;
	int hold_left = 0;
	bit hold_seen = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (hold_go && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = 400;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (rx_cyc % 48 == 0) begin
					case ($urandom_range(0, 4))
						0, 1: stall_pct = 0;
						2: stall_pct = 30;
						3: stall_pct = 70;
						default: stall_pct = 95;
					endcase
				end
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
			rx_cyc++;
		end
	end

	always @(posedge clk) begin
		entry_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (entry_results_q.size() == 0) begin
				$error("unexpected result: entry_kind %0d start_cluster %h", m_tuser, m_tdata[31:0]);
				fail_cnt++;
			end else begin
				want = entry_results_q.pop_front();
				if (m_tuser != want.kind) begin
					$error("entry_kind expected %0d actual %0d", want.kind, m_tuser);
					fail_cnt++;
				end
				if (m_tdata[31:0] != want.clus) begin
					$error("start_cluster expected %h actual %h", want.clus, m_tdata[31:0]);
					fail_cnt++;
				end
				if (m_tdata[32] != want.is_dir) begin
					$error("dir_flag expected %0d actual %0d", want.is_dir, m_tdata[32]);
					fail_cnt++;
				end
				if (m_tlast != want.done) begin
					$error("search_done expected %0d actual %0d", want.done, m_tlast);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		int          ph;
		int          mark;
		logic [63:0] lo;
		logic [23:0] hi;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		configure(64'h2020_2020_454C_4946, 24'h545854, 1'b1);
		add_fill(8'hFF, 1'b1);
		add_entry(GEN_DELETED, 1'b0, 32);
		add_entry(GEN_NEAR, 1'b0, 32);
		add_entry(GEN_OTHER, 1'b0, 32);
		add_entry(GEN_OTHER, 1'b0, 13);
		add_entry(GEN_MATCH, 1'b1, 32);
		add_noise(6, 1'b0);
		add_fill(8'h00, 1'b1);
		wait_idle();
		cfg_write(denm_pkg::REG_REPORT_ALL, 64'(0));
		add_entry(GEN_LONG, 1'b1, 32);
		add_entry(GEN_NEAR, 1'b0, 32);
		add_entry(GEN_MATCH, 1'b0, 32);
		wait_idle();

		ph = 0;
		while (items_queued < 1600) begin
			lo = {32'($urandom()), 32'($urandom())};
			hi = 24'($urandom());
			case (ph % 6)
				0: configure('1, '1, 1'b1);
				1: configure(lo, hi, 1'b0);
				2: configure('0, '0, 1'b1);
				3: configure(lo, hi, 1'b1);
				4: configure({lo[63:8], denm_pkg::DELETED_MARK}, hi, 1'b0);
				default: configure(lo, hi, 1'b1);
			endcase
			mark = items_queued;
			while (items_queued - mark < 230)
				add_search();
			if (ph % 6 == 3)
				hold_go <= 1'b1;
			wait_idle();
			ph++;
		end

		repeat (10) @(posedge clk);
		if (entry_results_q.size() != 0) begin
			$error("%0d expected results never arrived", entry_results_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
